// ----- hdl/apct_pkg.sv -----
// shared types and constants for the aabb pair contact tracker
// no dependencies; imported by every module of the block except apct_ram
package apct_pkg;

  localparam int ID_BITS_DEF = 8;
  localparam int ID_W        = 8;
  localparam int COORD_W     = 16;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_STAY  = 2'd2,
    EV_EXIT  = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_DECIDE
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]           left_id;
    logic [ID_W-1:0]           partner_id;
    logic signed [COORD_W-1:0] left_x;
    logic signed [COORD_W-1:0] left_y;
    logic [COORD_W-1:0]        left_w;
    logic [COORD_W-1:0]        left_h;
    logic signed [COORD_W-1:0] right_x;
    logic signed [COORD_W-1:0] right_y;
    logic [COORD_W-1:0]        right_w;
    logic [COORD_W-1:0]        right_h;
    logic                      left_dying;
    logic                      right_dying;
  } item_t;

  typedef struct packed {
    event_t contact_event;
    logic   boxes_overlap;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic calc;
    logic decide;
    logic clear;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
    logic clear_last;
  } status_t;

endpackage

// ----- hdl/apct_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module apct_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/apct_ctrl.sv -----
// sequencing state machine for the pair contact tracker
// depends on apct_pkg
module apct_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  apct_pkg::status_t st,
  output apct_pkg::cmd_t    cmd,
  output logic              item_stall
);
  import apct_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (st.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (item_valid) state_next = S_CALC;
      end
      S_CALC: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (!st.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_stall = 1'b1;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
      end
      S_IDLE: begin
        item_stall = 1'b0;
        cmd.accept = item_valid;
      end
      S_CALC: begin
        cmd.calc = 1'b1;
      end
      S_DECIDE: begin
        cmd.decide = !st.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ----- hdl/apct_dp.sv -----
// datapath: item register, overlap test, contact table and result register
// depends on apct_pkg and apct_ram
module apct_dp #(
  parameter int ID_BITS = apct_pkg::ID_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  apct_pkg::cmd_t    cmd,
  output apct_pkg::status_t st,
  input  apct_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output apct_pkg::result_t result
);
  import apct_pkg::*;

  localparam int PAIR_BITS = 2 * ID_BITS;
  localparam int DEPTH     = 1 << PAIR_BITS;

  item_t                item_q;
  logic [COORD_W-1:0]   adx, ady;
  logic [COORD_W:0]     sum_w, sum_h;
  logic [PAIR_BITS-1:0] clr_cnt;

  logic [ID_BITS+ID_W-1:0] lid_in_ext, rid_in_ext, lid_q_ext, rid_q_ext;
  logic [ID_BITS-1:0]      lid_in, rid_in, lid_q, rid_q;
  logic signed [COORD_W:0] dx, dy, dx_abs, dy_abs;
  logic                    ov, dying, same_id, prev, bit_next;
  event_t                  ev;
  logic                    wr_en;
  logic [PAIR_BITS-1:0]    wr_addr;
  logic [0:0]              wr_data, rd_data;

  // ids are masked to ID_BITS, zero-extended when ID_BITS exceeds the field
  assign lid_in_ext = {{ID_BITS{1'b0}}, item.left_id};
  assign rid_in_ext = {{ID_BITS{1'b0}}, item.partner_id};
  assign lid_q_ext  = {{ID_BITS{1'b0}}, item_q.left_id};
  assign rid_q_ext  = {{ID_BITS{1'b0}}, item_q.partner_id};
  assign lid_in     = lid_in_ext[ID_BITS-1:0];
  assign rid_in     = rid_in_ext[ID_BITS-1:0];
  assign lid_q      = lid_q_ext[ID_BITS-1:0];
  assign rid_q      = rid_q_ext[ID_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_q <= item;
    end
  end

  // calc stage: absolute distances and size sums
  always_comb begin
    dx     = {item_q.right_x[COORD_W-1], item_q.right_x}
           - {item_q.left_x[COORD_W-1], item_q.left_x};
    dy     = {item_q.right_y[COORD_W-1], item_q.right_y}
           - {item_q.left_y[COORD_W-1], item_q.left_y};
    dx_abs = dx[COORD_W] ? -dx : dx;
    dy_abs = dy[COORD_W] ? -dy : dy;
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      adx   <= dx_abs[COORD_W-1:0];
      ady   <= dy_abs[COORD_W-1:0];
      sum_w <= {1'b0, item_q.left_w} + {1'b0, item_q.right_w};
      sum_h <= {1'b0, item_q.left_h} + {1'b0, item_q.right_h};
    end
  end

  // decide stage: compare and event decision
  always_comb begin
    ov       = ({adx, 1'b0} <= sum_w) && ({ady, 1'b0} <= sum_h);
    dying    = item_q.left_dying | item_q.right_dying;
    same_id  = (lid_q == rid_q);
    prev     = rd_data[0];
    ev       = EV_NONE;
    bit_next = prev;
    if (!same_id) begin
      if (ov) begin
        if (prev) begin
          if (dying) begin
            ev       = EV_EXIT;
            bit_next = 1'b0;
          end else begin
            ev = EV_STAY;
          end
        end else if (!dying) begin
          ev       = EV_ENTER;
          bit_next = 1'b1;
        end
      end else if (prev) begin
        ev       = EV_EXIT;
        bit_next = 1'b0;
      end
    end
  end

  always_comb begin
    wr_en   = cmd.clear | (cmd.decide & !same_id);
    wr_addr = cmd.clear ? clr_cnt : {lid_q, rid_q};
    wr_data = cmd.clear ? 1'b0 : bit_next;
  end

  apct_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.accept),
    .rd_addr ({lid_in, rid_in}),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.decide) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      result.contact_event <= ev;
      result.boxes_overlap <= ov;
    end
  end

  assign st.out_busy   = result_valid & result_stall;
  assign st.clear_last = &clr_cnt;

endmodule

// ----- hdl/aabb_pair_contact_tracker_core.sv -----
// contact tracker for pairs of axis-aligned boxes: enter, stay and exit events
// depends on apct_pkg, apct_ctrl, apct_dp and apct_ram
//
// usage
//   item channel: item_valid / item_stall / item carry one collider pair per
//   transfer (ids, centres, full sizes, dying flags)
//   result channel: result_valid / result_stall / result carry one event and
//   the overlap flag per transfer, in item order
//   ordering: each item passes the calc and then the decide state, where its
//   result is registered; the next item is taken only after that decide;
//   the contact table is read on the transfer cycle and written back in the
//   decide cycle, so the next item waits for that write-back
//   a finished result sits in the output register while the next item is
//   taken; if the receiver stalls, the next result waits in the decide
//   cycle and item_stall stays high until the output register drains
//   reset: the contact table is cleared one entry per cycle, all 2^(2*ID_BITS)
//   entries (65536 at the default), with item_stall high throughout
module aabb_pair_contact_tracker_core #(
  parameter int ID_BITS = apct_pkg::ID_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  apct_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output apct_pkg::result_t result
);
  import apct_pkg::*;

  cmd_t    cmd;
  status_t st;

  // sequencer: clear pass, then accept / calc / decide per item
  apct_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .st         (st),
    .cmd        (cmd),
    .item_stall (item_stall)
  );

  // overlap arithmetic, contact table and output register
  apct_dp #(
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`ifndef SYNTH
  // no item is taken while the table is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> item_stall)
    else $error("item accepted during table clear");

  // a new result never overwrites one the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |-> !(result_valid && result_stall))
    else $error("result register overwritten while stalled");

  // every transfer is followed by the distance stage
  a_accept_then_calc: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> cmd.calc)
    else $error("distance stage skipped after transfer");

  // enter and stay only come with overlapping boxes
  a_enter_stay_overlap: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.contact_event == EV_ENTER ||
                      result.contact_event == EV_STAY)) |-> result.boxes_overlap)
    else $error("enter or stay without overlap");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// self-checking testbench for aabb_pair_contact_tracker_core (enter/stay/exit per box pair)
// depends on apct_pkg and the core; a directed table runs first, then random pair streams

module tb_top;
  import apct_pkg::*;

  localparam int MAX_WAIT     = 17;
  localparam int RANDOM_ITEMS = 1000;
  // limit covers the clear of all 65536 table entries plus the slowest legal item stream
  localparam int CYCLE_LIMIT  = 600000;
  localparam int REPORT_LIMIT = 10;
  localparam int DRAIN_CYCLES = 12;
  localparam int PAIR_KEYS    = 1 << (2 * ID_BITS_DEF);

  // one row of the directed table; typed rows carry their answer inline
  typedef struct {
    item_t   stim;
    bit      typed;
    result_t want;
  } plan_row_t;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  // shadow copy of the contact table, indexed by {left_id, partner_id}
  bit        contact_bits [PAIR_KEYS];
  result_t   pending_results [$];
  plan_row_t plan [$];
  result_t   oldest;

  int cycles;
  int mismatches;
  int directed_sent;
  int random_sent;
  int results_seen;
  int event_count [4];
  // per side: 0 sender, 1 receiver
  bit calm_mode [2];
  int draw_count [2];

  aabb_pair_contact_tracker_core DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // idle cycles before the next transfer; every 48 draws a side may switch
  // into a calm stretch with no idling at all
  function automatic int draw_wait(input int side);
    if (draw_count[side] % 48 == 0) begin
      calm_mode[side] = ($urandom_range(0, 2) == 0);
    end
    draw_count[side]++;
    return calm_mode[side] ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // one axis: doubled center distance against the summed full sizes
  function automatic bit axis_hit(input logic signed [15:0] pos_a, input logic [15:0] size_a,
                                  input logic signed [15:0] pos_b, input logic [15:0] size_b);
    int span;
    span = int'(pos_b) - int'(pos_a);
    if (span < 0) span = -span;
    return 2 * span <= int'(size_a) + int'(size_b);
  endfunction

  // predicts the event for one pair and updates the shadow table
  function automatic result_t track_contact(input item_t it);
    result_t          r;
    bit               was;
    bit               dying;
    logic [2*ID_W-1:0] key;
    r.boxes_overlap = axis_hit(it.left_x, it.left_w, it.right_x, it.right_w) &&
                      axis_hit(it.left_y, it.left_h, it.right_y, it.right_h);
    r.contact_event = EV_NONE;
    dying = it.left_dying | it.right_dying;
    key = {it.left_id, it.partner_id};
    // equal ids never touch the table
    if (it.left_id != it.partner_id) begin
      was = contact_bits[key];
      if (r.boxes_overlap && was && !dying) begin
        r.contact_event = EV_STAY;
      end else if (r.boxes_overlap && !was && !dying) begin
        r.contact_event = EV_ENTER;
        contact_bits[key] = 1'b1;
      end else if (was) begin
        // separated, or still touching but one side is going away
        r.contact_event = EV_EXIT;
        contact_bits[key] = 1'b0;
      end
    end
    return r;
  endfunction

  task automatic add_row(input int lid, rid, lx, ly, lw, lh, rx, ry, rw, rh,
                         input int ld, rd, typed, input event_t ev, input int ov);
    plan_row_t row;
    row.stim.left_id     = ID_W'(lid);
    row.stim.partner_id  = ID_W'(rid);
    row.stim.left_x      = COORD_W'(lx);
    row.stim.left_y      = COORD_W'(ly);
    row.stim.left_w      = COORD_W'(lw);
    row.stim.left_h      = COORD_W'(lh);
    row.stim.right_x     = COORD_W'(rx);
    row.stim.right_y     = COORD_W'(ry);
    row.stim.right_w     = COORD_W'(rw);
    row.stim.right_h     = COORD_W'(rh);
    row.stim.left_dying  = 1'(ld);
    row.stim.right_dying = 1'(rd);
    row.typed            = 1'(typed);
    row.want.contact_event = ev;
    row.want.boxes_overlap = 1'(ov);
    plan.push_back(row);
  endtask

  // mostly small sizes, now and then anything up to the full field
  function automatic logic [15:0] draw_size();
    int s;
    s = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 600);
    return 16'(s);
  endfunction

  // mostly well-formed pairs from a small id pool so contacts build up and
  // break down; the rest is raw noise over every bit of the item
  function automatic item_t random_pair();
    item_t        it;
    logic [159:0] noise;
    int           cx;
    int           cy;
    int           dx;
    int           dy;
    int           miss_axis;
    bit           hit;
    if ($urandom_range(0, 99) < 15) begin
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
      it = noise[$bits(item_t)-1:0];
      return it;
    end
    it.left_id    = ID_W'($urandom_range(0, 11));
    it.partner_id = ID_W'($urandom_range(0, 11));
    cx = int'($urandom_range(0, 4000)) - 2000;
    cy = int'($urandom_range(0, 4000)) - 2000;
    it.left_w  = draw_size();
    it.left_h  = draw_size();
    it.right_w = draw_size();
    it.right_h = draw_size();
    hit = ($urandom_range(0, 99) < 65);
    // 0 misses on x, 1 on y, 2 on both
    miss_axis = $urandom_range(0, 2);
    dx = (int'(it.left_w) + int'(it.right_w)) / 2;
    dy = (int'(it.left_h) + int'(it.right_h)) / 2;
    dx = (hit || miss_axis == 1) ? $urandom_range(0, dx) : dx + $urandom_range(1, 400);
    dy = (hit || miss_axis == 0) ? $urandom_range(0, dy) : dy + $urandom_range(1, 400);
    if ($urandom_range(0, 1)) dx = -dx;
    if ($urandom_range(0, 1)) dy = -dy;
    it.left_x  = COORD_W'(cx);
    it.left_y  = COORD_W'(cy);
    it.right_x = COORD_W'(cx + dx);
    it.right_y = COORD_W'(cy + dy);
    it.left_dying  = ($urandom_range(0, 7) == 0);
    it.right_dying = ($urandom_range(0, 7) == 0);
    return it;
  endfunction

  // one item transfer; returns at the accepting edge with item_valid still high
  task automatic send_item(input item_t stim, input bit typed, input result_t want);
    int      wait_cycles;
    result_t predicted;
    wait_cycles = draw_wait(0);
    if (wait_cycles > 0) begin
      item_valid <= 1'b0;
      repeat (wait_cycles) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= stim;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predicted = track_contact(stim);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // sender goes quiet until every outstanding result has come back
  task automatic hold_until_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input result_t want);
    if (mismatches < REPORT_LIMIT) begin
      $display("mismatch at cycle %0d (%s): expected event %0d overlap %0b, got event %0d overlap %0b",
               cycles, what, want.contact_event, want.boxes_overlap,
               result.contact_event, result.boxes_overlap);
    end
    mismatches++;
  endtask

  // receiver: random stall before each result transfer
  initial begin
    int wait_cycles;
    result_stall = 1'b0;
    forever begin
      wait_cycles = draw_wait(1);
      if (wait_cycles > 0) begin
        result_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  // result checker; results arrive in item order
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        oldest.contact_event = EV_NONE;
        oldest.boxes_overlap = 1'b0;
        report_mismatch("no result was due", oldest);
      end else begin
        oldest = pending_results.pop_front();
        if (result.contact_event !== oldest.contact_event ||
            result.boxes_overlap !== oldest.boxes_overlap) begin
          report_mismatch("field differs", oldest);
        end
        event_count[int'(oldest.contact_event)]++;
      end
    end
  end

  // watchdog; also covers the table clear after reset
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, pending_results.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;

    //      lid  rid  lx      ly      lw     lh     rx     ry      rw     rh     ld rd typed
    // enter, stay, exit on a dying left box, enter again, separate, stay apart
    add_row(1,   2,   0,      0,      10,    10,    0,     0,      10,    10,    0, 0, 1, EV_ENTER, 1);
    add_row(1,   2,   0,      0,      10,    10,    0,     0,      10,    10,    0, 0, 1, EV_STAY,  1);
    add_row(1,   2,   0,      0,      10,    10,    0,     0,      10,    10,    1, 0, 1, EV_EXIT,  1);
    add_row(1,   2,   0,      0,      10,    10,    0,     0,      10,    10,    0, 0, 0, EV_NONE,  0);
    add_row(1,   2,   0,      0,      10,    10,    100,   0,      10,    10,    0, 0, 1, EV_EXIT,  0);
    add_row(1,   2,   0,      0,      10,    10,    100,   0,      10,    10,    0, 0, 1, EV_NONE,  0);
    // reversed order is its own entry
    add_row(2,   1,   0,      0,      10,    10,    0,     0,      10,    10,    0, 0, 0, EV_NONE,  0);
    // same id on both sides: geometry only
    add_row(5,   5,   0,      0,      10,    10,    0,     0,      10,    10,    0, 0, 1, EV_NONE,  1);
    add_row(5,   5,   0,      0,      10,    10,    300,   0,      10,    10,    0, 0, 1, EV_NONE,  0);
    // dying pair never enters
    add_row(3,   4,   0,      0,      10,    10,    2,     2,      10,    10,    0, 1, 1, EV_NONE,  1);
    add_row(3,   4,   0,      0,      10,    10,    2,     2,      10,    10,    1, 1, 0, EV_NONE,  0);
    // coordinate extremes, edges exactly touching, then one pixel short
    add_row(10,  11,  -32768, 0,      65535, 0,     32767, 0,      65535, 0,     0, 0, 1, EV_ENTER, 1);
    add_row(10,  11,  -32768, 0,      65535, 0,     32767, 0,      65534, 0,     0, 0, 1, EV_EXIT,  0);
    add_row(12,  13,  0,      32767,  0,     65535, 0,     -32768, 0,     65535, 0, 0, 0, EV_NONE,  0);
    // zero-size boxes: shared center, on the edge, just outside
    add_row(20,  21,  -7,     9,      0,     0,     -7,    9,      0,     0,     0, 0, 1, EV_ENTER, 1);
    add_row(20,  21,  0,      0,      0,     0,     5,     0,      10,    0,     0, 0, 0, EV_NONE,  0);
    add_row(20,  21,  0,      0,      0,     0,     6,     0,      10,    0,     0, 0, 0, EV_NONE,  0);
    // id extremes with all-ones geometry, then corner-to-corner coordinates
    add_row(255, 0,   -1,     -1,     65535, 65535, -1,    -1,     65535, 65535, 0, 0, 0, EV_NONE,  0);
    add_row(0,   255, -1,     -1,     65535, 65535, -1,    -1,     65535, 65535, 0, 0, 0, EV_NONE,  0);
    add_row(255, 255, -1,     -1,     65535, 65535, -1,    -1,     65535, 65535, 1, 1, 1, EV_NONE,  1);
    add_row(255, 0,   -1,     -1,     65535, 65535, -1,    -1,     65535, 65535, 1, 0, 1, EV_EXIT,  1);
    add_row(0,   255, -32768, -32768, 0,     0,     32767, 32767,  0,     0,     0, 1, 0, EV_NONE,  0);
    // y alone misses by one pixel on a pair that is already clear
    add_row(1,   2,   0,      0,      10,    10,    0,     11,     10,    10,    0, 0, 1, EV_NONE,  0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // item_stall stays high through the table clear
    foreach (plan[i]) begin
      send_item(plan[i].stim, plan[i].typed, plan[i].want);
      directed_sent++;
    end
    hold_until_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) hold_until_drained();
      send_item(random_pair(), 1'b0, plan[0].want);
      random_sent++;
    end
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d directed and %0d random pair transfers, %0d results checked",
             directed_sent, random_sent, results_seen);
    $display("events: none %0d, enter %0d, stay %0d, exit %0d; mismatches %0d",
             event_count[0], event_count[1], event_count[2], event_count[3], mismatches);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
